[hw/rtl/rlbo_pkg.sv]
// Shared types and constants for the rectangle list best-overlap / bounding-box block.
package rlbo_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [7:0] {
    REG_TARGET_X      = 8'd0,
    REG_TARGET_Y      = 8'd1,
    REG_TARGET_WIDTH  = 8'd2,
    REG_TARGET_HEIGHT = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } rect_t;

  // One classified rectangle handed from the front pipeline to the accumulator.
  typedef struct packed {
    logic               last;
    logic               hit;
    logic [31:0]        area;
    rect_t              rect;
    logic signed [17:0] right;
    logic signed [17:0] bottom;
  } q_entry_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  index;
    rect_t       rect;
    logic [31:0] overlap;
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [16:0] box_w;
    logic [16:0] box_h;
  } res_t;

endpackage

[hw/rtl/rlbo_front.sv]
// Front pipeline: target registers, intersection test, overlap size and area.
module rlbo_front
  import rlbo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  rect_t       in_rect,
  input  logic        in_last,
  output logic        q_valid,
  input  logic        q_ready,
  output q_entry_t    q_data
);

  typedef struct packed {
    logic               last;
    logic               hit;
    logic signed [17:0] lx;
    logic signed [17:0] hx;
    logic signed [17:0] ly;
    logic signed [17:0] hy;
    rect_t              rect;
    logic signed [17:0] right;
    logic signed [17:0] bottom;
  } s1_t;

  typedef struct packed {
    logic               last;
    logic               hit;
    logic [15:0]        ow;
    logic [15:0]        oh;
    rect_t              rect;
    logic signed [17:0] right;
    logic signed [17:0] bottom;
  } s2_t;

  logic [15:0] tx_r, ty_r, tw_r, th_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r <= '0;
      ty_r <= '0;
      tw_r <= '0;
      th_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET_X:      tx_r <= cfg_data;
        REG_TARGET_Y:      ty_r <= cfg_data;
        REG_TARGET_WIDTH:  tw_r <= cfg_data;
        REG_TARGET_HEIGHT: th_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: inclusive edges, intersection test, clipped span
  logic signed [17:0] rx, ry, rx2, ry2, tx, ty, tx2, ty2;
  s1_t s1_nxt;

  always_comb begin
    rx  = $signed({{2{in_rect.x[15]}}, in_rect.x});
    ry  = $signed({{2{in_rect.y[15]}}, in_rect.y});
    tx  = $signed({{2{tx_r[15]}}, tx_r});
    ty  = $signed({{2{ty_r[15]}}, ty_r});
    rx2 = rx + $signed({2'b00, in_rect.w}) - 18'sd1;
    ry2 = ry + $signed({2'b00, in_rect.h}) - 18'sd1;
    tx2 = tx + $signed({2'b00, tw_r}) - 18'sd1;
    ty2 = ty + $signed({2'b00, th_r}) - 18'sd1;
    s1_nxt.last   = in_last;
    s1_nxt.hit    = !(rx > tx2 || rx2 < tx || ry > ty2 || ry2 < ty);
    s1_nxt.lx     = (rx > tx) ? rx : tx;
    s1_nxt.ly     = (ry > ty) ? ry : ty;
    s1_nxt.hx     = (rx2 < tx2) ? rx2 : tx2;
    s1_nxt.hy     = (ry2 < ty2) ? ry2 : ty2;
    s1_nxt.rect   = in_rect;
    s1_nxt.right  = rx2;
    s1_nxt.bottom = ry2;
  end

  logic s1_valid_r, s2_valid_r, s3_valid_r;
  s1_t  s1_r;
  s2_t  s2_r, s2_nxt;
  q_entry_t s3_r, s3_nxt;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready = !s3_valid_r || q_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage 2: overlap width and height (only meaningful on a hit)
  logic signed [17:0] ow_full, oh_full;

  always_comb begin
    ow_full       = s1_r.hx - s1_r.lx + 18'sd1;
    oh_full       = s1_r.hy - s1_r.ly + 18'sd1;
    s2_nxt.last   = s1_r.last;
    s2_nxt.hit    = s1_r.hit;
    s2_nxt.ow     = ow_full[15:0];
    s2_nxt.oh     = oh_full[15:0];
    s2_nxt.rect   = s1_r.rect;
    s2_nxt.right  = s1_r.right;
    s2_nxt.bottom = s1_r.bottom;
  end

  // Stage 3: area
  always_comb begin
    s3_nxt.last   = s2_r.last;
    s3_nxt.hit    = s2_r.hit;
    s3_nxt.area   = 32'(s2_r.ow) * 32'(s2_r.oh);
    s3_nxt.rect   = s2_r.rect;
    s3_nxt.right  = s2_r.right;
    s3_nxt.bottom = s2_r.bottom;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid)   s1_r <= s1_nxt;
    if (s2_ready && s1_valid_r) s2_r <= s2_nxt;
    if (s3_ready && s2_valid_r) s3_r <= s3_nxt;
  end

  assign q_valid = s3_valid_r;
  assign q_data  = s3_r;

endmodule

[hw/rtl/rlbo_queue.sv]
// Short queue between the front pipeline and the accumulator.
module rlbo_queue
  import rlbo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  q_entry_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output q_entry_t rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               push, pop;

  assign wr_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

[hw/rtl/rlbo_back.sv]
// Accumulator: best-overlap selection, bounding box, list position and result register.
module rlbo_back
  import rlbo_pkg::*;
#(
  parameter int MAX_ITEMS = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_ready,
  input  q_entry_t q_data,
  output logic     res_valid,
  input  logic     res_ready,
  output res_t     res_data
);

  localparam int CNT_W = $clog2(MAX_ITEMS);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               best_valid_r, best_valid_nxt;
  logic [31:0]        best_area_r, best_area_nxt;
  logic [CNT_W-1:0]   best_pos_r, best_pos_nxt;
  rect_t              best_rect_r, best_rect_nxt;
  logic signed [15:0] min_left_r, min_left_nxt, min_top_r, min_top_nxt;
  logic signed [17:0] max_right_r, max_right_nxt, max_bottom_r, max_bottom_nxt;
  logic               out_valid_r;
  res_t               out_r, res_nxt;

  logic               pop, take, first;
  logic signed [15:0] rx, ry;
  logic signed [18:0] bw_full, bh_full;
  logic [CNT_W+7:0]   pos_ext;

  // A last word may only retire when the result register is free.
  assign q_ready = !q_data.last || !out_valid_r || res_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    rx    = $signed(q_data.rect.x);
    ry    = $signed(q_data.rect.y);
    first = (cnt_r == '0);
    take  = q_data.hit && (!best_valid_r || q_data.area > best_area_r);

    best_valid_nxt = best_valid_r | q_data.hit;
    best_area_nxt  = take ? q_data.area : best_area_r;
    best_pos_nxt   = take ? cnt_r : best_pos_r;
    best_rect_nxt  = take ? q_data.rect : best_rect_r;

    min_left_nxt   = (first || rx < min_left_r) ? rx : min_left_r;
    min_top_nxt    = (first || ry < min_top_r) ? ry : min_top_r;
    max_right_nxt  = (first || q_data.right > max_right_r) ? q_data.right : max_right_r;
    max_bottom_nxt = (first || q_data.bottom > max_bottom_r) ? q_data.bottom : max_bottom_r;

    cnt_nxt = (cnt_r < CNT_W'(MAX_ITEMS - 1)) ? cnt_r + 1'b1 : cnt_r;

    bw_full = {max_right_nxt[17], max_right_nxt}
            - {{3{min_left_nxt[15]}}, min_left_nxt} + 19'sd1;
    bh_full = {max_bottom_nxt[17], max_bottom_nxt}
            - {{3{min_top_nxt[15]}}, min_top_nxt} + 19'sd1;
    pos_ext = {8'b0, best_pos_nxt};

    res_nxt.found   = best_valid_nxt;
    res_nxt.index   = best_valid_nxt ? pos_ext[7:0] : 8'd0;
    res_nxt.rect    = best_valid_nxt ? best_rect_nxt : '0;
    res_nxt.overlap = best_valid_nxt ? best_area_nxt : 32'd0;
    res_nxt.box_x   = min_left_nxt;
    res_nxt.box_y   = min_top_nxt;
    res_nxt.box_w   = bw_full[16:0];
    res_nxt.box_h   = bh_full[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      best_valid_r <= 1'b0;
      best_area_r  <= '0;
      best_pos_r   <= '0;
      best_rect_r  <= '0;
      min_left_r   <= '0;
      min_top_r    <= '0;
      max_right_r  <= '0;
      max_bottom_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        if (q_data.last) begin
          cnt_r        <= '0;
          best_valid_r <= 1'b0;
          best_area_r  <= '0;
          best_pos_r   <= '0;
          best_rect_r  <= '0;
          min_left_r   <= '0;
          min_top_r    <= '0;
          max_right_r  <= '0;
          max_bottom_r <= '0;
        end else begin
          cnt_r        <= cnt_nxt;
          best_valid_r <= best_valid_nxt;
          best_area_r  <= best_area_nxt;
          best_pos_r   <= best_pos_nxt;
          best_rect_r  <= best_rect_nxt;
          min_left_r   <= min_left_nxt;
          min_top_r    <= min_top_nxt;
          max_right_r  <= max_right_nxt;
          max_bottom_r <= max_bottom_nxt;
        end
      end
      if (pop && q_data.last) out_valid_r <= 1'b1;
      else if (res_ready)     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.last) out_r <= res_nxt;
  end

  assign res_valid = out_valid_r;
  assign res_data  = out_r;

endmodule

[hw/rtl/rect_list_best_overlap_bbox.sv]
// Top level: best-overlap rectangle and bounding box over a streamed rectangle list.
// Throughput: one rectangle word per clock unless stalled; a held-off output backs up into the input.
// Path: the last word of a list passes three front stages
// (test, overlap size, 16x16 area multiply), then the queue, and the accumulator registers the result.
// Reset (rst_n, synchronous, active low): target registers and list state cleared,
// pipeline and queue emptied.
module rect_list_best_overlap_bbox
  import rlbo_pkg::*;
#(
  parameter int MAX_ITEMS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // rect_x, rect_y, rect_width, rect_height
  input  logic         in_tlast,   // last_item
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // match_index, match_x, match_y, match_width,
                                   // match_height, match_overlap, box_x, box_y,
                                   // box_width, box_height, zero pad
  output logic         out_tuser   // match_found
);

  rect_t    in_rect;
  logic     q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  q_entry_t q_in_data, q_out_data;
  res_t     res;

  assign cfg_ready = 1'b1;

  assign in_rect.x = in_tdata[15:0];
  assign in_rect.y = in_tdata[31:16];
  assign in_rect.w = in_tdata[47:32];
  assign in_rect.h = in_tdata[63:48];

  rlbo_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_rect   (in_rect),
    .in_last   (in_tlast),
    .q_valid   (q_in_valid),
    .q_ready   (q_in_ready),
    .q_data    (q_in_data)
  );

  rlbo_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_in_valid),
    .wr_ready (q_in_ready),
    .wr_data  (q_in_data),
    .rd_valid (q_out_valid),
    .rd_ready (q_out_ready),
    .rd_data  (q_out_data)
  );

  rlbo_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_data    (q_out_data),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (res)
  );

  assign out_tuser = res.found;
  assign out_tdata = {6'b0, res.box_h, res.box_w, res.box_y, res.box_x, res.overlap,
                      res.rect.h, res.rect.w, res.rect.y, res.rect.x, res.index};

endmodule

[sim/rect_list_best_overlap_bbox_checker.sv]
// Checker for the rectangle list block: predicts best match and bounding box, compares results.
`timescale 1ns / 1ps

module rect_list_best_overlap_bbox_checker
  import rlbo_pkg::*;
#(
  parameter int MAX_ITEMS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [63:0]  in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [175:0] out_tdata,
  input  logic         out_tuser,
  output int           mismatches,
  output int           expected_left
);

  // target copy
  logic signed [15:0] tgt_x, tgt_y;
  logic [15:0]        tgt_w, tgt_h;

  // running list state
  int unsigned list_pos;
  bit          have_best;
  logic [31:0] best_overlap;
  int unsigned best_pos;
  rect_t       best_rect;
  longint      box_l, box_t, box_r, box_b;

  res_t expected_results[$];

  task automatic clear_list();
    list_pos     = 0;
    have_best    = 1'b0;
    best_overlap = '0;
    best_pos     = 0;
    best_rect    = '0;
    box_l        = 0;
    box_t        = 0;
    box_r        = 0;
    box_b        = 0;
  endtask

  function automatic res_t unpack_result(logic [175:0] d, logic user);
    res_t r;
    r.found   = user;
    r.index   = d[7:0];
    r.rect.x  = d[23:8];
    r.rect.y  = d[39:24];
    r.rect.w  = d[55:40];
    r.rect.h  = d[71:56];
    r.overlap = d[103:72];
    r.box_x   = d[119:104];
    r.box_y   = d[135:120];
    r.box_w   = d[152:136];
    r.box_h   = d[169:153];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Fold one rectangle into the list state; on the last word queue the result.
  task automatic fold_rect(input rect_t r, input logic last);
    longint      rx, ry, rx2, ry2, tx, ty, tx2, ty2;
    longint      ow, oh, span;
    logic [63:0] prod, wide;
    logic [31:0] area;
    res_t        res;
    rx  = longint'($signed(r.x));
    ry  = longint'($signed(r.y));
    rx2 = rx + longint'(r.w) - 1;
    ry2 = ry + longint'(r.h) - 1;
    tx  = longint'(tgt_x);
    ty  = longint'(tgt_y);
    tx2 = tx + longint'(tgt_w) - 1;
    ty2 = ty + longint'(tgt_h) - 1;

    if (!(rx > tx2 || rx2 < tx || ry > ty2 || ry2 < ty)) begin
      ow   = ((rx2 < tx2) ? rx2 : tx2) - ((rx > tx) ? rx : tx) + 1;
      oh   = ((ry2 < ty2) ? ry2 : ty2) - ((ry > ty) ? ry : ty) + 1;
      prod = ow * oh;
      area = prod[31:0];
      // ties keep the earlier rectangle
      if (!have_best || area > best_overlap) begin
        have_best    = 1'b1;
        best_overlap = area;
        best_pos     = list_pos;
        best_rect    = r;
      end
    end

    if (list_pos == 0) begin
      box_l = rx;
      box_t = ry;
      box_r = rx2;
      box_b = ry2;
    end else begin
      if (rx < box_l) box_l = rx;
      if (ry < box_t) box_t = ry;
      if (rx2 > box_r) box_r = rx2;
      if (ry2 > box_b) box_b = ry2;
    end

    if (list_pos < MAX_ITEMS - 1) list_pos++;

    if (last) begin
      res.found   = have_best;
      res.index   = have_best ? best_pos[7:0] : 8'd0;
      res.rect    = have_best ? best_rect : '0;
      res.overlap = have_best ? best_overlap : 32'd0;
      res.box_x   = box_l[15:0];
      res.box_y   = box_t[15:0];
      span        = box_r - box_l + 1;
      wide        = span;
      res.box_w   = wide[16:0];
      span        = box_b - box_t + 1;
      wide        = span;
      res.box_h   = wide[16:0];
      expected_results.push_back(res);
      clear_list();
    end
  endtask

  always @(posedge clk) begin : watch
    res_t  want, got;
    rect_t r;
    if (!rst_n) begin
      tgt_x = '0;
      tgt_y = '0;
      tgt_w = '0;
      tgt_h = '0;
      clear_list();
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = unpack_result(out_tdata, out_tuser);
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected, expected none, actual %0h/%0b",
                   $time, out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("match_found", want.found, got.found);
          check_field("match_index", want.index, got.index);
          check_field("match_x", want.rect.x, got.rect.x);
          check_field("match_y", want.rect.y, got.rect.y);
          check_field("match_width", want.rect.w, got.rect.w);
          check_field("match_height", want.rect.h, got.rect.h);
          check_field("match_overlap", want.overlap, got.overlap);
          check_field("box_x", want.box_x, got.box_x);
          check_field("box_y", want.box_y, got.box_y);
          check_field("box_width", want.box_w, got.box_w);
          check_field("box_height", want.box_h, got.box_h);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_X:      tgt_x = cfg_data;
          REG_TARGET_Y:      tgt_y = cfg_data;
          REG_TARGET_WIDTH:  tgt_w = cfg_data;
          REG_TARGET_HEIGHT: tgt_h = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        r.x = in_tdata[15:0];
        r.y = in_tdata[31:16];
        r.w = in_tdata[47:32];
        r.h = in_tdata[63:48];
        fold_rect(r, in_tlast);
      end
    end
    expected_left = expected_results.size();
  end

endmodule

[sim/rect_list_best_overlap_bbox_tb.sv]
// Testbench top for the rectangle list block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rect_list_best_overlap_bbox_tb
  import rlbo_pkg::*;
();

  localparam int MAX_ITEMS    = 256;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready;
  logic [175:0] out_tdata;
  logic         out_tuser;

  int mismatches;
  int expected_left;

  // stimulus-side view of the current target, used to aim rectangles
  logic signed [15:0] tgt_x = '0, tgt_y = '0;
  logic [15:0]        tgt_w = '0, tgt_h = '0;

  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  bit calm      = 1'b0;
  bit quiet     = 1'b0;

  int unsigned cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rect_list_best_overlap_bbox #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  rect_list_best_overlap_bbox_checker #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .mismatches   (mismatches),
    .expected_left(expected_left)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rect_list_best_overlap_bbox test failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Called at a falling edge with the block idle; leaves cfg_valid low.
  task automatic set_target(input logic [15:0] x, y, w, h);
    cfg_reg_t    regs [4];
    logic [15:0] vals [4];
    regs = '{REG_TARGET_X, REG_TARGET_Y, REG_TARGET_WIDTH, REG_TARGET_HEIGHT};
    vals = '{x, y, w, h};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    tgt_x = x;
    tgt_y = y;
    tgt_w = w;
    tgt_h = h;
  endtask

  task automatic send_rect(input logic [15:0] x, y, w, h, input logic last);
    if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {h, w, y, x};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Mostly rectangles around the target, some fully random, some degenerate.
  task automatic pick_rect(output logic [15:0] x, y, w, h);
    int kind, cx, cy, sx, sy;
    kind = $urandom_range(0, 9);
    cx   = int'(tgt_x);
    cy   = int'(tgt_y);
    sx   = (tgt_w > 2000) ? 2000 : int'(tgt_w);
    sy   = (tgt_h > 2000) ? 2000 : int'(tgt_h);
    if (kind < 2) begin
      x = 16'($urandom);
      y = 16'($urandom);
      w = 16'($urandom);
      h = 16'($urandom);
    end else begin
      x = 16'(cx - 150 + int'($urandom_range(0, sx + 300)));
      y = 16'(cy - 150 + int'($urandom_range(0, sy + 300)));
      w = 16'($urandom_range(0, 400));
      h = 16'($urandom_range(0, 400));
      if (kind == 8) begin
        if ($urandom_range(0, 1)) w = '0;
        else h = '0;
      end else if (kind == 9) begin
        w = 16'($urandom);
        h = 16'($urandom);
      end
    end
  endtask

  task automatic run_lists(input int total, input int max_len);
    int sent, len;
    logic [15:0] x, y, w, h;
    sent = 0;
    while (sent < total) begin
      len   = $urandom_range(1, max_len);
      len   = (len > total - sent) ? total - sent : len;
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        pick_rect(x, y, w, h);
        send_rect(x, y, w, h, i == len - 1);
      end
      sent += len;
    end
    quiet = 1'b0;
  endtask

  // index saturates: the best rectangle sits well past position 255
  task automatic long_list();
    logic [15:0] x, y, w, h;
    for (int i = 0; i < 300; i++) begin
      if (i == 280) begin
        x = tgt_x;
        y = tgt_y;
        w = tgt_w;
        h = tgt_h;
      end else begin
        pick_rect(x, y, w, h);
      end
      send_rect(x, y, w, h, i == 299);
    end
  endtask

  task automatic finish_phase();
    in_tvalid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset target (zero size) while the result side holds off for a long stretch
    hold_req = 1'b1;
    run_lists(40, 3);
    finish_phase();

    // directed: target spans x 100..299, y -50..29
    set_target(16'd100, -16'sd50, 16'd200, 16'd80);
    send_rect(16'd400, 16'd100, 16'd10, 16'd10, 1'b1);          // miss
    send_rect(16'd150, 16'd0, 16'd0, 16'd10, 1'b1);             // zero width inside span
    send_rect(16'd120, -16'sd40, 16'd10, 16'd10, 1'b0);         // first hit
    send_rect(16'd130, -16'sd40, 16'd5, 16'd5, 1'b0);           // smaller
    send_rect(16'd140, -16'sd30, 16'd10, 16'd10, 1'b0);         // tie, kept first
    send_rect(16'd50, -16'sd100, 16'd300, 16'd200, 1'b0);       // covers target
    send_rect(16'd0, 16'd0, 16'd1, 16'd1, 1'b1);                // miss
    send_rect(16'd90, -16'sd50, 16'd11, 16'd1, 1'b0);           // touches left edge
    send_rect(16'd300, -16'sd50, 16'd5, 16'd5, 1'b0);           // just right of target
    send_rect(16'd100, 16'd30, 16'd5, 16'd5, 1'b1);             // just below target
    send_rect(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0);
    send_rect(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_rect(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_rect(16'd1000, 16'd1000, 16'd1, 16'd1, 1'b0);
    send_rect(16'd2000, -16'sd2000, 16'd3, 16'd3, 1'b1);        // list with no hit
    send_rect(16'd5, 16'd5, 16'd0, 16'd0, 1'b1);                // empty rectangle
    finish_phase();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_target(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
        1: set_target(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        2: set_target(16'h7FFF, 16'h8000, 16'd1, 16'd1);
        3: set_target(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: set_target(16'($urandom), 16'($urandom),
                            16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)));
      endcase
      if (p == 0) long_list();
      run_lists(60, 8);
      finish_phase();
    end

    // closing stretch without any idling
    calm = 1'b1;
    set_target(16'($urandom), 16'($urandom),
               16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)));
    run_lists(100, 6);
    finish_phase();

    if (mismatches == 0 && expected_left == 0)
      $display("rect_list_best_overlap_bbox test passed");
    else
      $display("rect_list_best_overlap_bbox test failed");
    $finish;
  end

endmodule
